@@ rtl/swsv_pkg.sv @@
// Shared types for the stack with sorted view unit.
// Depends on nothing; used by swsv_ctrl, swsv_dp, the top level and the checker.
package swsv_pkg;

   typedef enum logic [1:0] {
      OP_PUSH = 2'd0,
      OP_POP  = 2'd1,
      OP_LIST = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PUSH,
      S_POP_TOP,
      S_SCAN,
      S_DEL,
      S_LIST
   } state_type;

   typedef enum logic [2:0] {
      PTR_HOLD,
      PTR_LOAD,
      PTR_CLEAR,
      PTR_INC,
      PTR_DEC
   } ptr_op_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC
   } cnt_op_type;

   typedef enum logic [2:0] {
      RD_CNT_M1,
      RD_PTR_M2,
      RD_ZERO,
      RD_PTR_P1,
      RD_PTR_P2
   } rd_sel_type;

   typedef enum logic [1:0] {
      VAL_ZERO,
      VAL_ITEM,
      VAL_RD
   } val_sel_type;

   typedef struct packed {
      logic        latch_val;
      logic        stack_wr;
      logic        latch_item;
      ptr_op_type  ptr_op;
      cnt_op_type  cnt_op;
      rd_sel_type  rd_sel;
      logic        sort_wr;
      logic        sort_wr_val;
      logic        emit;
      status_type  status;
      val_sel_type val_sel;
      logic        last_from_ptr;
   } cmd_type;

   typedef struct packed {
      logic cnt_zero;
      logic cnt_full;
      logic ptr_zero;
      logic ptr_last;
      logic rd_gt_val;
      logic rd_eq_item;
   } stat_type;

endpackage

@@ rtl/swsv_ctrl.sv @@
// Controller state machine: sequences push, pop and list transactions.
// Depends on swsv_pkg; drives the command struct of swsv_dp.
module swsv_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [1:0]          req_operation,
   input  swsv_pkg::stat_type  stat,
   output swsv_pkg::cmd_type   cmd,
   output logic                busy
);

   swsv_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= swsv_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != swsv_pkg::S_IDLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         swsv_pkg::S_IDLE: begin
            if (start) begin
               case (req_operation)
                  swsv_pkg::OP_PUSH: if (!stat.cnt_full) state_in = swsv_pkg::S_PUSH;
                  swsv_pkg::OP_POP:  if (!stat.cnt_zero) state_in = swsv_pkg::S_POP_TOP;
                  swsv_pkg::OP_LIST: if (!stat.cnt_zero) state_in = swsv_pkg::S_LIST;
                  default:           state_in = swsv_pkg::S_IDLE;
               endcase
            end
         end
         swsv_pkg::S_PUSH: begin
            if (stat.ptr_zero || !stat.rd_gt_val) state_in = swsv_pkg::S_IDLE;
         end
         swsv_pkg::S_POP_TOP: state_in = swsv_pkg::S_SCAN;
         swsv_pkg::S_SCAN: begin
            if (stat.rd_eq_item || stat.ptr_last) state_in = swsv_pkg::S_DEL;
         end
         swsv_pkg::S_DEL: begin
            if (stat.ptr_last) state_in = swsv_pkg::S_IDLE;
         end
         swsv_pkg::S_LIST: begin
            if (stat.ptr_last) state_in = swsv_pkg::S_IDLE;
         end
         default: state_in = swsv_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd               = '0;
      cmd.ptr_op        = swsv_pkg::PTR_HOLD;
      cmd.cnt_op        = swsv_pkg::CNT_HOLD;
      cmd.rd_sel        = swsv_pkg::RD_ZERO;
      cmd.status        = swsv_pkg::STAT_OK;
      cmd.val_sel       = swsv_pkg::VAL_ZERO;
      case (state_ff)
         swsv_pkg::S_IDLE: begin
            if (start) begin
               case (req_operation)
                  swsv_pkg::OP_PUSH: begin
                     if (stat.cnt_full) begin
                        cmd.emit   = 1'b1;
                        cmd.status = swsv_pkg::STAT_FULL;
                     end else begin
                        cmd.stack_wr  = 1'b1;
                        cmd.latch_val = 1'b1;
                        cmd.ptr_op    = swsv_pkg::PTR_LOAD;
                        cmd.rd_sel    = swsv_pkg::RD_CNT_M1;
                     end
                  end
                  swsv_pkg::OP_POP: begin
                     if (stat.cnt_zero) begin
                        cmd.emit   = 1'b1;
                        cmd.status = swsv_pkg::STAT_EMPTY;
                     end
                  end
                  swsv_pkg::OP_LIST: begin
                     if (stat.cnt_zero) begin
                        cmd.emit   = 1'b1;
                        cmd.status = swsv_pkg::STAT_EMPTY;
                     end else begin
                        cmd.ptr_op = swsv_pkg::PTR_CLEAR;
                        cmd.rd_sel = swsv_pkg::RD_ZERO;
                     end
                  end
                  default: cmd.emit = 1'b0;
               endcase
            end
         end
         swsv_pkg::S_PUSH: begin
            cmd.sort_wr = 1'b1;
            if (!stat.ptr_zero && stat.rd_gt_val) begin
               cmd.ptr_op = swsv_pkg::PTR_DEC;
               cmd.rd_sel = swsv_pkg::RD_PTR_M2;
            end else begin
               cmd.sort_wr_val = 1'b1;
               cmd.cnt_op      = swsv_pkg::CNT_INC;
               cmd.emit        = 1'b1;
            end
         end
         swsv_pkg::S_POP_TOP: begin
            cmd.latch_item = 1'b1;
            cmd.ptr_op     = swsv_pkg::PTR_CLEAR;
            cmd.rd_sel     = swsv_pkg::RD_ZERO;
         end
         swsv_pkg::S_SCAN: begin
            cmd.rd_sel = swsv_pkg::RD_PTR_P1;
            if (!(stat.rd_eq_item || stat.ptr_last)) cmd.ptr_op = swsv_pkg::PTR_INC;
         end
         swsv_pkg::S_DEL: begin
            if (stat.ptr_last) begin
               cmd.cnt_op  = swsv_pkg::CNT_DEC;
               cmd.emit    = 1'b1;
               cmd.val_sel = swsv_pkg::VAL_ITEM;
            end else begin
               cmd.sort_wr = 1'b1;
               cmd.ptr_op  = swsv_pkg::PTR_INC;
               cmd.rd_sel  = swsv_pkg::RD_PTR_P2;
            end
         end
         swsv_pkg::S_LIST: begin
            cmd.emit          = 1'b1;
            cmd.val_sel       = swsv_pkg::VAL_RD;
            cmd.last_from_ptr = 1'b1;
            cmd.ptr_op        = swsv_pkg::PTR_INC;
            cmd.rd_sel        = swsv_pkg::RD_PTR_P1;
         end
         default: cmd.emit = 1'b0;
      endcase
   end

endmodule

@@ rtl/swsv_dp.sv @@
// Datapath: stack memory, sorted memory, entry count, walk pointer, result register.
// Depends on swsv_pkg; commanded by swsv_ctrl.
module swsv_dp #(
   parameter int DEPTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  swsv_pkg::cmd_type   cmd,
   output swsv_pkg::stat_type  stat,
   input  logic signed [31:0]  req_value,
   output logic                rsp_valid,
   output logic [1:0]          rsp_status,
   output logic signed [31:0]  rsp_value_out,
   output logic                rsp_last
);

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = CW + 1;

   logic [31:0]        stack_mem [0:DEPTH-1];
   logic [31:0]        sort_mem  [0:DEPTH-1];

   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      ptr_ff, ptr_in;
   logic signed [31:0] val_ff;
   logic [31:0]        item_ff;
   logic [31:0]        top_ff;
   logic [31:0]        srd_ff;
   logic [AW-1:0]      cnt_x, ptr_x, rd_raw, top_raw;
   logic [IW-1:0]      rd_addr, top_addr;
   logic [31:0]        sort_wdata;
   logic               rsp_valid_ff;
   logic [1:0]         rsp_status_ff;
   logic [31:0]        rsp_value_ff;
   logic               rsp_last_ff;

   assign cnt_x   = AW'(count_ff);
   assign ptr_x   = AW'(ptr_ff);
   assign top_raw = cnt_x - AW'(1);

   always_comb begin
      case (cmd.rd_sel)
         swsv_pkg::RD_CNT_M1: rd_raw = cnt_x - AW'(1);
         swsv_pkg::RD_PTR_M2: rd_raw = ptr_x - AW'(2);
         swsv_pkg::RD_PTR_P1: rd_raw = ptr_x + AW'(1);
         swsv_pkg::RD_PTR_P2: rd_raw = ptr_x + AW'(2);
         default:             rd_raw = '0;
      endcase
   end

   assign rd_addr  = (rd_raw < AW'(DEPTH)) ? rd_raw[IW-1:0] : '0;
   assign top_addr = (top_raw < AW'(DEPTH)) ? top_raw[IW-1:0] : '0;

   assign stat.cnt_zero   = (count_ff == '0);
   assign stat.cnt_full   = (cnt_x == AW'(DEPTH));
   assign stat.ptr_zero   = (ptr_ff == '0);
   assign stat.ptr_last   = ((ptr_x + AW'(1)) >= cnt_x);
   assign stat.rd_gt_val  = ($signed(srd_ff) > val_ff);
   assign stat.rd_eq_item = (srd_ff == item_ff);

   assign sort_wdata = cmd.sort_wr_val ? val_ff : srd_ff;

   always_ff @(posedge clock) begin
      if (cmd.stack_wr) begin
         stack_mem[count_ff[IW-1:0]] <= req_value;
      end
      top_ff <= stack_mem[top_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.sort_wr) begin
         sort_mem[ptr_ff[IW-1:0]] <= sort_wdata;
      end
      srd_ff <= sort_mem[rd_addr];
   end

   always_comb begin
      case (cmd.cnt_op)
         swsv_pkg::CNT_INC: count_in = count_ff + CW'(1);
         swsv_pkg::CNT_DEC: count_in = count_ff - CW'(1);
         default:           count_in = count_ff;
      endcase
   end

   always_comb begin
      case (cmd.ptr_op)
         swsv_pkg::PTR_LOAD:  ptr_in = count_ff;
         swsv_pkg::PTR_CLEAR: ptr_in = '0;
         swsv_pkg::PTR_INC:   ptr_in = ptr_ff + CW'(1);
         swsv_pkg::PTR_DEC:   ptr_in = ptr_ff - CW'(1);
         default:             ptr_in = ptr_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_val) val_ff <= req_value;
      if (cmd.latch_item) item_ff <= top_ff;
      if (cmd.emit) begin
         rsp_status_ff <= cmd.status;
         rsp_last_ff   <= cmd.last_from_ptr ? stat.ptr_last : 1'b1;
         case (cmd.val_sel)
            swsv_pkg::VAL_ITEM: rsp_value_ff <= item_ff;
            swsv_pkg::VAL_RD:   rsp_value_ff <= srd_ff;
            default:            rsp_value_ff <= '0;
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

@@ rtl/stack_with_sorted_view_unit.sv @@
// Top level of the stack with sorted view unit: controller plus datapath.
// Depends on swsv_pkg, swsv_ctrl and swsv_dp.
//
//   channel    ports                                      transfer
//   request    start, busy, req_operation, req_value      start && !busy
//   response   rsp_valid, rsp_status, rsp_value_out,      rsp_valid, one cycle
//              rsp_last
//
// Push: k = sorted entries moved up (at most DEPTH-1); a push to a full stack is refused.
// Pop: read the top entry, scan the sorted memory for the match, then close the gap.
// List: n results on consecutive cycles, after the first entry is read; empty is refused.
// All walks are set by the single read port of the sorted memory, one entry a cycle.
// Synchronous reset empties the stack; memory contents are not cleared.
// Results are registered and cannot be stalled; a new start may coincide with the last one.
module stack_with_sorted_view_unit #(
   parameter int DEPTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_operation,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_value_out,
   output logic               rsp_last
);

   swsv_pkg::cmd_type  cmd;
   swsv_pkg::stat_type stat;

   swsv_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .stat          (stat),
      .cmd           (cmd),
      .busy          (busy)
   );

   swsv_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_value_out (rsp_value_out),
      .rsp_last      (rsp_last)
   );

endmodule

@@ rtl/swsv_checker.sv @@
// Port-level checks for stack_with_sorted_view_unit, attached by bind.
// Depends on swsv_pkg.
module swsv_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [1:0]  req_operation,
   input logic        rsp_valid,
   input logic [1:0]  rsp_status,
   input logic        rsp_last
);

   a_refusal_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == swsv_pkg::STAT_FULL || rsp_status == swsv_pkg::STAT_EMPTY)
      |-> rsp_last)
      else $error("refused transaction not marked last");

   a_accept_reacts: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_operation == swsv_pkg::OP_PUSH ||
         req_operation == swsv_pkg::OP_POP || req_operation == swsv_pkg::OP_LIST)
      |=> busy || rsp_valid)
      else $error("accepted transaction produced no activity");

   a_list_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid)
      else $error("list stream broken before last");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !busy)
      else $error("busy after final result");

   a_busy_from_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy without start");

endmodule

bind stack_with_sorted_view_unit swsv_checker u_swsv_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_operation (req_operation),
   .rsp_valid     (rsp_valid),
   .rsp_status    (rsp_status),
   .rsp_last      (rsp_last)
);

@@ tb/tb_stack_with_sorted_view_unit.sv @@
// Testbench for stack_with_sorted_view_unit: directed and random push, pop and list
// transactions, each checked field by field against a tracker of the stack and its sorted view.
// Depends on swsv_pkg and the RTL of stack_with_sorted_view_unit.

typedef logic signed [31:0] word_type;

typedef struct {
   swsv_pkg::status_type status;
   word_type             value;
   logic                 last;
} predicted_result_type;

class sorted_stack_tracker;
   int                   depth;
   int                   errors;
   word_type             stack_vals[$];
   word_type             sorted_vals[$];
   predicted_result_type pending_results[$];

   function new(int depth_i);
      depth = depth_i;
      errors = 0;
   endfunction

   function void add_expected(swsv_pkg::status_type st, word_type val, logic last);
      predicted_result_type r;
      r.status = st;
      r.value = val;
      r.last = last;
      pending_results.push_back(r);
   endfunction

   task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
   endtask

   // Accepted transaction: update the tracked stack and queue its results.
   function void note_request(logic [1:0] op, word_type val);
      word_type item;
      int       idx;
      case (op)
         swsv_pkg::OP_PUSH: begin
            if (stack_vals.size() >= depth) begin
               add_expected(swsv_pkg::STAT_FULL, '0, 1'b1);
            end else begin
               stack_vals.push_back(val);
               idx = 0;
               while (idx < sorted_vals.size() && sorted_vals[idx] <= val) idx++;
               sorted_vals.insert(idx, val);
               add_expected(swsv_pkg::STAT_OK, '0, 1'b1);
            end
         end
         swsv_pkg::OP_POP: begin
            if (stack_vals.size() == 0) begin
               add_expected(swsv_pkg::STAT_EMPTY, '0, 1'b1);
            end else begin
               item = stack_vals.pop_back();
               idx = 0;
               while (idx < sorted_vals.size() && sorted_vals[idx] != item) idx++;
               if (idx == sorted_vals.size()) idx = sorted_vals.size() - 1;
               sorted_vals.delete(idx);
               add_expected(swsv_pkg::STAT_OK, item, 1'b1);
            end
         end
         swsv_pkg::OP_LIST: begin
            if (sorted_vals.size() == 0) begin
               add_expected(swsv_pkg::STAT_EMPTY, '0, 1'b1);
            end else begin
               for (int i = 0; i < sorted_vals.size(); i++) begin
                  add_expected(swsv_pkg::STAT_OK, sorted_vals[i], i == sorted_vals.size() - 1);
               end
            end
         end
         default: ;
      endcase
   endfunction

   task check_result(logic [1:0] status, word_type value, logic last);
      predicted_result_type r;
      if (pending_results.size() == 0) begin
         report($sformatf("result with nothing outstanding: status %0d value %0d last %0b",
                          status, value, last));
      end else begin
         r = pending_results.pop_front();
         if (status !== r.status) begin
            report($sformatf("status %0d, predicted %0d", status, r.status));
         end
         if (value !== r.value) begin
            report($sformatf("value_out %0d, predicted %0d", value, r.value));
         end
         if (last !== r.last) begin
            report($sformatf("last %0b, predicted %0b", last, r.last));
         end
      end
   endtask

   function int outstanding();
      return pending_results.size();
   endfunction
endclass

module tb_stack_with_sorted_view_unit;
   localparam int         STACK_DEPTH    = 32;
   localparam int         RANDOM_ITEMS   = 420;
   localparam int         PHASE_ITEMS    = 40;
   localparam int         QUIET_PHASE    = 60;
   localparam int         WATCHDOG_LIMIT = 1000;
   localparam int         DRAIN_CYCLES   = 80;
   localparam logic [1:0] OP_UNUSED      = 2'd3;

   localparam int MODE_FILL  = 0;
   localparam int MODE_DRAIN = 1;
   localparam int MODE_MIXED = 2;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_operation = swsv_pkg::OP_PUSH;
   word_type    req_value = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   word_type    rsp_value_out;
   logic        rsp_last;

   sorted_stack_tracker tracker;
   int                  quiet_cycles = 0;

   stack_with_sorted_view_unit #(.DEPTH(STACK_DEPTH)) u_top (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_operation (req_operation),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_value_out (rsp_value_out),
      .rsp_last      (rsp_last)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         tracker.check_result(rsp_status, rsp_value_out, rsp_last);
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic issue(input logic [1:0] op, input word_type val);
      start = 1'b1;
      req_operation = op;
      req_value = val;
      @(posedge clock);
      while (busy) @(posedge clock);
      tracker.note_request(op, val);
      @(negedge clock);
   endtask

   task automatic idle_for(input int cycles);
      start = 1'b0;
      for (int i = 0; i < cycles; i++) begin
         req_operation = 2'($urandom);
         req_value = $urandom;
         @(negedge clock);
      end
   endtask

   function automatic word_type pick_value();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4) return word_type'($urandom_range(0, 7)) - 4;
      if (r == 4) begin
         case ($urandom_range(0, 3))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return '0;
            default: return -1;
         endcase
      end
      return $urandom;
   endfunction

   function automatic logic [1:0] pick_op(input int mode);
      int r;
      int push_lim;
      int list_lim;
      r = $urandom_range(0, 99);
      case (mode)
         MODE_FILL:  begin push_lim = 80; list_lim = 88; end
         MODE_DRAIN: begin push_lim = 15; list_lim = 25; end
         default:    begin push_lim = 45; list_lim = 57; end
      endcase
      if (r < push_lim) return swsv_pkg::OP_PUSH;
      if (r < list_lim) return swsv_pkg::OP_LIST;
      if (r < 96) return swsv_pkg::OP_POP;
      return OP_UNUSED;
   endfunction

   initial begin
      int         counted;
      int         mode;
      int         idle_pct;
      logic [1:0] op;

      tracker = new(STACK_DEPTH);
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty cases, extremes, duplicates, unused operation code
      issue(swsv_pkg::OP_LIST, 32'sh12345678);
      issue(swsv_pkg::OP_POP, '0);
      issue(OP_UNUSED, -1);
      issue(swsv_pkg::OP_PUSH, 32'sh7fffffff);
      issue(swsv_pkg::OP_PUSH, 32'sh80000000);
      idle_for(3);
      issue(swsv_pkg::OP_PUSH, '0);
      issue(swsv_pkg::OP_PUSH, -1);
      issue(swsv_pkg::OP_PUSH, 1);
      issue(swsv_pkg::OP_PUSH, 5);
      issue(swsv_pkg::OP_PUSH, 5);
      issue(swsv_pkg::OP_PUSH, -7);
      issue(swsv_pkg::OP_LIST, '0);
      issue(swsv_pkg::OP_POP, 32'sh55555555);
      issue(swsv_pkg::OP_POP, '0);
      idle_for(1);
      issue(swsv_pkg::OP_LIST, '1);
      issue(swsv_pkg::OP_PUSH, 32'sh80000000);
      issue(swsv_pkg::OP_PUSH, 32'sh7fffffff);
      issue(OP_UNUSED, 32'sh2aaaaaaa);
      issue(swsv_pkg::OP_LIST, '0);
      issue(swsv_pkg::OP_POP, '0);
      issue(swsv_pkg::OP_POP, '0);

      counted = 0;
      mode = MODE_FILL;
      idle_pct = 0;
      while (counted < RANDOM_ITEMS) begin
         if (counted % PHASE_ITEMS == 0) begin
            mode = (counted / PHASE_ITEMS) % 3;
            idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 35;
         end
         if (counted > RANDOM_ITEMS - QUIET_PHASE) idle_pct = 0;
         op = pick_op(mode);
         issue(op, pick_value());
         if (op != OP_UNUSED) counted++;
         if ($urandom_range(0, 99) < idle_pct) idle_for($urandom_range(1, 14));
      end
      start = 1'b0;

      while (tracker.outstanding() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (tracker.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
